/* design/interval_table_binary_search_macros.svh */
// Assertion macros for the interval table binary search block.
`ifndef INTERVAL_TABLE_BINARY_SEARCH_MACROS_SVH
`define INTERVAL_TABLE_BINARY_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ITBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ITBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/itbs_pkg.sv */
// Package: widths, codes and the sequencer program of the interval table search.
package itbs_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int VALUE_W         = 31;
    localparam int OFFSET_W        = 11;
    localparam int INDEX_W         = 10;
    localparam int POS_W           = 32;
    localparam int OP_W            = 2;
    localparam int ADJ_W           = VALUE_W + 2;

    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = -11'sd10;
    localparam logic signed [ADJ_W-1:0]    POS_MAX      = 33'sd2147483647;

    // Item operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // Sequencer steps; ST_CHECK directly follows ST_IDLE
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] ST_CHECK = 3'd1;
    localparam logic [STEP_W-1:0] ST_RD0   = 3'd2;
    localparam logic [STEP_W-1:0] ST_RD1   = 3'd3;
    localparam logic [STEP_W-1:0] ST_RD2   = 3'd4;
    localparam logic [STEP_W-1:0] ST_HIT   = 3'd5;

    // Jump conditions
    localparam logic [2:0] C_NEVER     = 3'd0;
    localparam logic [2:0] C_ALWAYS    = 3'd1;
    localparam logic [2:0] C_NO_LOOKUP = 3'd2;  // no lookup item accepted
    localparam logic [2:0] C_EMPTY     = 3'd3;  // search range exhausted
    localparam logic [2:0] C_BELOW     = 3'd4;  // adjusted value below start[mid]
    localparam logic [2:0] C_PAST      = 3'd5;  // adjusted value at or above start[mid+1], mid not last

    // Table read address select
    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_MID  = 2'd1;
    localparam logic [1:0] RD_MID1 = 2'd2;

    // One control word. Taken jump goes to target, else to the next step.
    // hi_dec, lo_inc and emit_miss act only when the jump is taken.
    typedef struct packed {
        logic [1:0]        rd_sel;
        logic              ld_mid;
        logic              ld_low;
        logic              dispatch;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
        logic              hi_dec;
        logic              lo_inc;
        logic              emit_miss;
        logic              emit_hit;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '0;
        unique case (step)
            ST_IDLE:
            begin
                w.dispatch = 1'b1;
                w.cond     = C_NO_LOOKUP;
                w.target   = ST_IDLE;
            end
            ST_CHECK:
            begin
                w.ld_mid    = 1'b1;
                w.cond      = C_EMPTY;
                w.target    = ST_IDLE;
                w.emit_miss = 1'b1;
            end
            ST_RD0:
            begin
                w.rd_sel = RD_MID;
                w.cond   = C_NEVER;
            end
            ST_RD1:
            begin
                w.rd_sel = RD_MID1;
                w.ld_low = 1'b1;
                w.cond   = C_BELOW;
                w.target = ST_CHECK;
                w.hi_dec = 1'b1;
            end
            ST_RD2:
            begin
                w.cond   = C_PAST;
                w.target = ST_CHECK;
                w.lo_inc = 1'b1;
            end
            ST_HIT:
            begin
                w.emit_hit = 1'b1;
                w.cond     = C_ALWAYS;
                w.target   = ST_IDLE;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* design/interval_table_binary_search.sv */
// Interval table binary search: table storage, sequencer and result register.
//
// Clear and append items keep busy low; a clear or an append with room
// gives no result. An append to a full table gives one overflow result
// on done the cycle after it is accepted. A lookup holds busy high while
// a microcoded sequencer runs a binary search over the filled entries:
// each probe does a range check, a read of start[mid] and a test against
// start[mid], plus a test against the upper bound start[mid+1] when that
// bound must be tested, since the table memory has a single read port
// with registered read data. A lookup's result appears on done for one
// cycle as busy falls. done cannot be held off: every result is taken in
// the cycle it is shown. bound_offset is written with bound_offset_we and
// should change only while the block is idle.
module interval_table_binary_search
    import itbs_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [OP_W-1:0]            operation,
    input  logic [VALUE_W-1:0]         item_value,
    input  logic                       bound_offset_we,
    input  logic signed [OFFSET_W-1:0] bound_offset,
    output logic                       done,
    output logic                       found,
    output logic [INDEX_W-1:0]         interval_index,
    output logic signed [POS_W-1:0]    local_position,
    output logic                       overflow
);

`include "interval_table_binary_search_macros.svh"

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Table memory and registers
    logic [VALUE_W-1:0]         start_table [TABLE_DEPTH];
    logic [VALUE_W-1:0]         rdata_reg;
    logic [STEP_W-1:0]          upc_reg, upc_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic signed [CNT_W:0]      lo_reg, lo_next;
    logic signed [CNT_W:0]      hi_reg, hi_next;
    logic [IDX_W-1:0]           mid_reg, mid_next;
    logic [VALUE_W-1:0]         value_reg;
    logic signed [ADJ_W-1:0]    vadj_reg;
    logic [VALUE_W-1:0]         low_reg;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic                       done_reg, done_next;
    logic                       found_reg, found_next;
    logic [INDEX_W-1:0]         index_reg, index_next;
    logic signed [POS_W-1:0]    pos_reg, pos_next;
    logic                       ovf_reg, ovf_next;

    // Datapath wires
    ucode_t                     uw;
    logic                       accept;
    logic                       table_full;
    logic                       mem_we;
    logic [IDX_W-1:0]           raddr;
    logic                       below;
    logic                       last;
    logic                       take;
    logic [CNT_W:0]             range_sum;
    logic [CNT_W-1:0]           range_half;
    logic signed [ADJ_W-1:0]    pos_wide;
    logic [IDX_W+INDEX_W-1:0]   mid_wide;

    assign uw         = ucode_rom(upc_reg);
    assign busy       = (upc_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));
    assign mem_we     = uw.dispatch && accept && (operation == OP_APPEND) && !table_full;

    // Compare against the adjusted value: v < s + off  <=>  v - off < s
    assign below      = vadj_reg < $signed({2'b00, rdata_reg});
    assign last       = (CNT_W'(mid_reg) + 1'b1) >= count_reg;
    assign range_sum  = $unsigned(lo_reg) + $unsigned(hi_reg);
    assign range_half = range_sum[CNT_W:1];
    assign pos_wide   = $signed({2'b00, value_reg}) - $signed({2'b00, low_reg})
                        + $signed(ADJ_W'(1));
    assign mid_wide   = {{INDEX_W{1'b0}}, mid_reg};

    // Select the table read address
    always_comb
    begin
        case (uw.rd_sel)
            RD_MID1: raddr = mid_reg + 1'b1;
            default: raddr = mid_reg;
        endcase
    end

    // Evaluate the jump condition
    always_comb
    begin
        unique case (uw.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_LOOKUP: take = !(accept && (operation == OP_LOOKUP));
            C_EMPTY:     take = lo_reg > hi_reg;
            C_BELOW:     take = below;
            C_PAST:      take = !last && !below;
            default:     take = 1'b0;
        endcase
    end

    // Sequencer and search range
    always_comb
    begin
        upc_next   = take ? uw.target : upc_reg + 1'b1;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        if (uw.dispatch && accept)
        begin
            if (operation == OP_CLEAR)
            begin
                count_next = '0;
            end
            if (mem_we)
            begin
                count_next = count_reg + 1'b1;
            end
            if (operation == OP_LOOKUP)
            begin
                lo_next = '0;
                hi_next = $signed({1'b0, count_reg}) - 2'sd1;
            end
        end
        if (uw.ld_mid)
        begin
            mid_next = range_half[IDX_W-1:0];
        end
        if (uw.hi_dec && take)
        begin
            hi_next = $signed({1'b0, CNT_W'(mid_reg)}) - 2'sd1;
        end
        if (uw.lo_inc && take)
        begin
            lo_next = $signed({1'b0, CNT_W'(mid_reg)}) + 2'sd1;
        end
    end

    // Build the result item
    always_comb
    begin
        done_next  = 1'b0;
        found_next = 1'b0;
        index_next = '0;
        pos_next   = '0;
        ovf_next   = 1'b0;
        if (uw.dispatch && accept && (operation == OP_APPEND) && table_full)
        begin
            done_next = 1'b1;
            ovf_next  = 1'b1;
        end
        if (uw.emit_miss && take)
        begin
            done_next = 1'b1;
        end
        if (uw.emit_hit)
        begin
            done_next  = 1'b1;
            found_next = 1'b1;
            index_next = mid_wide[INDEX_W-1:0];
            pos_next   = (pos_wide > POS_MAX) ? POS_MAX[POS_W-1:0] : pos_wide[POS_W-1:0];
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg    <= ST_IDLE;
            count_reg  <= '0;
            offset_reg <= OFFSET_RESET;
            done_reg   <= 1'b0;
        end
        else
        begin
            upc_reg   <= upc_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (bound_offset_we)
            begin
                offset_reg <= bound_offset;
            end
        end
    end

    // Hold search and result payload
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        found_reg <= found_next;
        index_reg <= index_next;
        pos_reg   <= pos_next;
        ovf_reg   <= ovf_next;
        if (uw.ld_low)
        begin
            low_reg <= rdata_reg;
        end
        if (uw.dispatch && accept)
        begin
            value_reg <= item_value;
            vadj_reg  <= $signed({2'b00, item_value}) - ADJ_W'(offset_reg);
        end
    end

    // Table memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            start_table[count_reg[IDX_W-1:0]] <= item_value;
        end
        rdata_reg <= start_table[raddr];
    end

    assign done           = done_reg;
    assign found          = found_reg;
    assign interval_index = index_reg;
    assign local_position = pos_reg;
    assign overflow       = ovf_reg;

    // Checks
    `ITBS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH), "entry count past depth")
    `ITBS_ASSERT_NEXT(a_lookup_busy, accept && (operation == OP_LOOKUP), busy, "lookup did not start")
    `ITBS_ASSERT_NOW(a_hit_in_range, done && found, CNT_W'(mid_reg) < count_reg, "hit index beyond table fill")
    `ITBS_ASSERT_NOW(a_done_source, done, $past(upc_reg == ST_HIT || upc_reg == ST_CHECK || accept), "result without cause")

endmodule
